### hw/rtl/mlp_backprop_momentum_trainer_defines.svh
// Assertion macros shared by the checker files of the trainer.
`ifndef MLP_BACKPROP_MOMENTUM_TRAINER_DEFINES_SVH
`define MLP_BACKPROP_MOMENTUM_TRAINER_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define MBT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define MBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mbt_pkg.sv
// Types, constants and helper functions of the trainer.
`timescale 1ns / 1ps
package mbt_pkg;

    localparam int INPUT_COUNT         = 3;
    localparam int OUTPUT_COUNT        = 1;
    localparam int FRACTION_BITS       = 10;
    localparam int SIGMOID_TABLE_DEPTH = 256;

    localparam int WEIGHT_W  = 16;
    localparam int ACT_W     = FRACTION_BITS + 1;
    localparam int ERR_W     = FRACTION_BITS + 2;
    localparam int RATE_W    = 11;
    localparam int ACC_W     = 40;
    localparam int PROD_W    = 48;
    localparam int MUL_W     = 32;
    localparam int TAB_BITS  = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int W_IDX_W   = $clog2(INPUT_COUNT + 1);
    localparam int ONE       = 1 << FRACTION_BITS;

    // Forward pass per node: one step per input, one to finish the sum,
    // one for the table, one to hand the node on.
    localparam int FWD_LAST  = INPUT_COUNT + 2;
    // Update pass per node: four delta steps, then four steps per weight.
    localparam int UPD_LAST  = 4 + 4 * (INPUT_COUNT + 2) - 1;
    localparam int STEP_W    = $clog2(UPD_LAST + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM      = 1'b1;
    localparam logic [RATE_W-1:0] LR_RESET  = 11'd307;
    localparam logic [RATE_W-1:0] MOM_RESET = 11'd922;

    typedef enum logic [1:0] {
        OP_TRAIN = 2'd0,
        OP_INFER = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD,
        ST_OUT_SIG,
        ST_OUT_DELTA,
        ST_HID_UPD,
        ST_BIAS_UPD,
        ST_ACCESS,
        ST_FINISH
    } state_t;

    // Everything the ring keeps for one hidden node; w and c index INPUT_COUNT
    // is the bias, wo and co are the node's output weight and change term.
    typedef struct packed {
        logic [INPUT_COUNT:0][WEIGHT_W-1:0] w;
        logic [INPUT_COUNT:0][WEIGHT_W-1:0] c;
        logic [WEIGHT_W-1:0]                wo;
        logic [WEIGHT_W-1:0]                co;
        logic [ACT_W-1:0]                   h;
    } node_rec_t;

    localparam logic signed [PROD_W-1:0] SAT_HI = 32767;
    localparam logic signed [PROD_W-1:0] SAT_LO = -32768;

    // Shift right by s, rounding half up.
    function automatic logic signed [PROD_W-1:0] shr_round(
        input logic signed [PROD_W-1:0] v,
        input int                       s
    );
        logic signed [PROD_W-1:0] half;
        half = '0;
        half[s-1] = 1'b1;
        return (v + half) >>> s;
    endfunction

    function automatic logic [WEIGHT_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
        logic [WEIGHT_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[WEIGHT_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[WEIGHT_W-1:0];
        else
            r = v[WEIGHT_W-1:0];
        return r;
    endfunction

    // Unsigned quotient by shift and subtract, used only while the table is built.
    function automatic longint unsigned udiv64(
        input longint unsigned n,
        input longint unsigned d
    );
        longint unsigned q;
        longint unsigned rem;
        int              b;
        q   = '0;
        rem = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], n[b]};
            if (rem >= d)
            begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sigmoid table entry k, built from an exp series in Q30 at elaboration.
    function automatic logic [ACT_W-1:0] sig_entry(input int k);
        longint            t;
        longint unsigned   mag;
        longint unsigned   g;
        longint unsigned   term;
        longint unsigned   e;
        longint unsigned   den;
        longint unsigned   num;
        longint unsigned   q30;
        longint            sum;
        longint unsigned   usum;
        int                i;
        int                r;
        q30  = 64'd1 << 30;
        t    = 16 * longint'(k) - 8 * longint'(SIGMOID_TABLE_DEPTH);
        mag  = (t < 0) ? longint'(-t) : longint'(t);
        g    = (mag << 30) / (8 * SIGMOID_TABLE_DEPTH);
        sum  = longint'(q30);
        term = q30;
        for (i = 1; i <= 24; i++) begin
            term = udiv64((term * g) >> 30, longint'(i));
            if (i % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        usum = longint'(sum);
        for (r = 0; r < 3; r++)
            usum = (usum * usum + (q30 >> 1)) >> 30;
        e   = usum;
        den = q30 + e;
        num = (t >= 0) ? (longint'(ONE) << 30) : (e << FRACTION_BITS);
        return ACT_W'(udiv64(num + (den >> 1), den));
    endfunction

endpackage

### hw/rtl/mbt_if.sv
// Command and result channel interfaces of the trainer.
`timescale 1ns / 1ps
interface mbt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic [10:0] target;
    logic [6:0]  weight_index;
    logic signed [15:0] weight_value;

    modport source (output valid, operation, feature_0, feature_1, feature_2, target,
                    weight_index, weight_value, input ready);
    modport sink (input valid, operation, feature_0, feature_1, feature_2, target,
                  weight_index, weight_value, output ready);
endinterface

interface mbt_rsp_if;
    logic        valid;
    logic        ready;
    logic [10:0] activation;
    logic signed [11:0] output_error;
    logic [10:0] squared_error;
    logic signed [15:0] weight_read;

    modport source (output valid, activation, output_error, squared_error, weight_read,
                    input ready);
    modport sink (input valid, activation, output_error, squared_error, weight_read,
                  output ready);
endinterface

### hw/rtl/mbt_cell.sv
// One ring cell: holds the weights and change terms of one hidden node.
`timescale 1ns / 1ps
module mbt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift_en,
    input  mbt_pkg::node_rec_t rec_in,
    output mbt_pkg::node_rec_t rec_out
);
    import mbt_pkg::*;

    node_rec_t rec_reg;
    node_rec_t rec_next;

    always_comb
    begin
        rec_next = shift_en ? rec_in : rec_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rec_reg <= '0;
        else
            rec_reg <= rec_next;
    end

    assign rec_out = rec_reg;
endmodule

### hw/rtl/mbt_sigmoid.sv
// Rounds and clamps a pre-activation and looks up the sigmoid, registered.
`timescale 1ns / 1ps
module mbt_sigmoid (
    input  logic                                clk,
    input  logic signed [mbt_pkg::ACC_W-1:0]    acc,
    output logic        [mbt_pkg::ACT_W-1:0]    y
);
    import mbt_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [ACC_W-1:0] V_LO = -(8 * ONE);
    localparam logic signed [ACC_W-1:0] V_HI = 8 * ONE - 1;
    localparam logic signed [ACC_W-1:0] V_OFS = 8 * ONE;

    logic [ACT_W-1:0] table_w [SIGMOID_TABLE_DEPTH];
    logic signed [ACC_W-1:0] v;
    logic signed [ACC_W-1:0] vc;
    logic        [ACC_W-1:0] ofs;
    logic [TAB_BITS-1:0]     idx;
    logic [ACT_W-1:0]        y_reg;
    logic [ACT_W-1:0]        y_next;

    for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++)
    begin : g_tab
        localparam logic [ACT_W-1:0] ENTRY = sig_entry(k);
        assign table_w[k] = ENTRY;
    end

    always_comb
    begin
        v = (acc + HALF) >>> FRACTION_BITS;
        if (v < V_LO)
            vc = V_LO;
        else if (v > V_HI)
            vc = V_HI;
        else
            vc = v;
        ofs    = vc + V_OFS;
        // The offset value lies in [0, 16 ONE); its top bits are the index.
        idx    = ofs[FRACTION_BITS+3 -: TAB_BITS];
        y_next = table_w[idx];
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign y = y_reg;
endmodule

### hw/rtl/mlp_backprop_momentum_trainer.sv
// Top level: a ring of hidden-node cells around one shared multiply unit.
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    operation, feature_0..2, target, weight_index, weight_value
//   rsp      out  valid/ready    activation, output_error, squared_error, weight_read
//   cfg      in   cfg_wr_en      cfg_index, cfg_data (learning_rate, momentum)
//
// One item at a time. The cell ring turns once per pass, one node per step,
// and every product goes through the single 32x32 multiplier.
// Reset clears all weights and change terms at once; no clearing pass.
// A new item is taken while the previous result waits in the output register.
`timescale 1ns / 1ps
module mlp_backprop_momentum_trainer #(
    parameter int HIDDEN_COUNT = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mbt_cmd_if.sink                           cmd,
    mbt_rsp_if.source                         rsp,
    input  logic                              cfg_wr_en,
    input  logic [mbt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbt_pkg::RATE_W-1:0]        cfg_data
);
    import mbt_pkg::*;

    localparam int NW     = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
    localparam int HID_W  = HIDDEN_COUNT * (INPUT_COUNT + 1);
    localparam int AW_RAW = $clog2(HID_W + HIDDEN_COUNT + 1);
    localparam int AW     = (AW_RAW > 7) ? AW_RAW : 7;
    localparam int KW     = STEP_W - 2;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NW-1:0]     node_reg, node_next;

    op_t               op_reg, op_next;
    logic signed [WEIGHT_W-1:0] x_reg [INPUT_COUNT];
    logic signed [WEIGHT_W-1:0] x_next [INPUT_COUNT];
    logic [ACT_W-1:0]  tgt_reg, tgt_next;
    logic [6:0]        idx_reg, idx_next;
    logic [WEIGHT_W-1:0] val_reg, val_next;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  oacc_reg, oacc_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [MUL_W-1:0]  tmp_reg, tmp_next;
    logic signed [PROD_W-1:0] tot_reg, tot_next;
    logic signed [WEIGHT_W-1:0] hd_reg, hd_next;
    logic signed [WEIGHT_W-1:0] od_reg, od_next;
    logic [ACT_W-1:0]  y_reg, y_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [ACT_W-1:0]  sq_reg, sq_next;
    logic [WEIGHT_W-1:0] rd_reg, rd_next;
    node_rec_t         work_reg, work_next;
    logic [WEIGHT_W-1:0] wob_reg, wob_next;
    logic [WEIGHT_W-1:0] cob_reg, cob_next;
    logic [RATE_W-1:0] lr_reg, lr_next;
    logic [RATE_W-1:0] mom_reg, mom_next;

    logic              out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]  out_act_reg, out_act_next;
    logic signed [ERR_W-1:0] out_err_reg, out_err_next;
    logic [ACT_W-1:0]  out_sq_reg, out_sq_next;
    logic [WEIGHT_W-1:0] out_wr_reg, out_wr_next;

    node_rec_t ring [HIDDEN_COUNT];
    node_rec_t head;
    node_rec_t tail_in;
    node_rec_t acc_rec;
    logic      shift_en;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod_full;
    logic signed [ACC_W-1:0]   sig_in;
    logic [ACT_W-1:0]          sig_y;

    logic [KW-1:0]         kk;
    logic [W_IDX_W-1:0]    kidx;
    logic [W_IDX_W-1:0]    jidx;
    logic [1:0]            uph;
    logic signed [MUL_W-1:0] upd_x, upd_d, upd_c;
    logic [WEIGHT_W-1:0]   upd_w;
    logic signed [PROD_W-1:0] upd_sum, upd_wsum;
    logic [WEIGHT_W-1:0]   new_c, new_w;
    logic [ACT_W-1:0]      tgt_sat;
    logic [AW-1:0]         idx_ext, base;
    logic [W_IDX_W-1:0]    fsel;
    logic                  node_last;
    logic                  cmd_acc;
    logic signed [PROD_W-1:0] od_rnd, hd_rnd, sq_rnd;

    // Ring of cells: the head is processed, the result re-enters at the tail.
    for (genvar k = 0; k < HIDDEN_COUNT; k++)
    begin : g_ring
        node_rec_t cell_in;
        if (k == HIDDEN_COUNT - 1)
        begin : g_tail
            assign cell_in = tail_in;
        end
        else
        begin : g_mid
            assign cell_in = ring[k+1];
        end
        mbt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .rec_in   (cell_in),
            .rec_out  (ring[k])
        );
    end

    assign head = ring[0];

    mbt_sigmoid u_sigmoid (
        .clk (clk),
        .acc (sig_in),
        .y   (sig_y)
    );

    assign sig_in    = (state_reg == ST_OUT_SIG) ? oacc_reg : acc_reg;
    assign prod_full = mul_a * mul_b;
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign node_last = (node_reg == NW'(HIDDEN_COUNT - 1));
    assign kk        = step_reg[STEP_W-1:2] - KW'(1);
    assign kidx      = kk[W_IDX_W-1:0];
    assign jidx      = step_reg[W_IDX_W-1:0];
    assign uph       = step_reg[1:0];
    assign tgt_sat   = (tgt_reg > ACT_W'(ONE)) ? ACT_W'(ONE) : tgt_reg;
    assign od_rnd    = shr_round(prod_reg, 2 * FRACTION_BITS);
    assign hd_rnd    = shr_round(prod_reg, 3 * FRACTION_BITS);
    assign sq_rnd    = shr_round(prod_reg, FRACTION_BITS);

    // Operands of the weight update: hidden weights by step, then the output weight; the output bias in ST_BIAS_UPD.
    always_comb
    begin
        if (state_reg == ST_BIAS_UPD) begin
            upd_x = MUL_W'(ONE);
            upd_d = MUL_W'(od_reg);
            upd_c = MUL_W'($signed(cob_reg));
            upd_w = wob_reg;
        end
        else if (kk < KW'(INPUT_COUNT)) begin
            upd_x = MUL_W'(x_reg[kidx]);
            upd_d = MUL_W'(hd_reg);
            upd_c = MUL_W'($signed(work_reg.c[kidx]));
            upd_w = work_reg.w[kidx];
        end
        else if (kk == KW'(INPUT_COUNT)) begin
            upd_x = MUL_W'(ONE);
            upd_d = MUL_W'(hd_reg);
            upd_c = MUL_W'($signed(work_reg.c[kidx]));
            upd_w = work_reg.w[kidx];
        end
        else begin
            upd_x = MUL_W'($signed({1'b0, work_reg.h}));
            upd_d = MUL_W'(od_reg);
            upd_c = MUL_W'($signed(work_reg.co));
            upd_w = work_reg.wo;
        end
        upd_sum  = tot_reg + (prod_reg <<< FRACTION_BITS);
        new_c    = sat16(shr_round(upd_sum, 10 + FRACTION_BITS));
        upd_wsum = PROD_W'($signed(upd_w)) + PROD_W'($signed(new_c));
        new_w    = sat16(upd_wsum);
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        node_next      = node_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        tgt_next       = tgt_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        acc_next       = acc_reg;
        oacc_next      = oacc_reg;
        prod_next      = prod_reg;
        tmp_next       = tmp_reg;
        tot_next       = tot_reg;
        hd_next        = hd_reg;
        od_next        = od_reg;
        y_next         = y_reg;
        err_next       = err_reg;
        sq_next        = sq_reg;
        rd_next        = rd_reg;
        work_next      = work_reg;
        wob_next       = wob_reg;
        cob_next       = cob_reg;
        out_valid_next = out_valid_reg;
        out_act_next   = out_act_reg;
        out_err_next   = out_err_reg;
        out_sq_next    = out_sq_reg;
        out_wr_next    = out_wr_reg;
        mul_a          = '0;
        mul_b          = '0;
        tail_in        = head;
        acc_rec        = head;
        shift_en       = 1'b0;
        idx_ext        = AW'(idx_reg);
        base           = AW'(node_reg * (INPUT_COUNT + 1));
        fsel           = W_IDX_W'(idx_ext - base);

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc) begin
                    op_next   = op_t'(cmd.operation);
                    x_next[0] = cmd.feature_0;
                    if (INPUT_COUNT > 1)
                        x_next[1 % INPUT_COUNT] = cmd.feature_1;
                    if (INPUT_COUNT > 2)
                        x_next[2 % INPUT_COUNT] = cmd.feature_2;
                    tgt_next  = cmd.target;
                    idx_next  = cmd.weight_index;
                    val_next  = cmd.weight_value;
                    step_next = '0;
                    node_next = '0;
                    oacc_next = ACC_W'($signed(wob_reg)) <<< FRACTION_BITS;
                    rd_next   = '0;
                    if (cmd.operation == OP_TRAIN || cmd.operation == OP_INFER)
                        state_next = ST_FWD;
                    else
                        state_next = ST_ACCESS;
                end
            end
            ST_FWD:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg < STEP_W'(INPUT_COUNT)) begin
                    mul_a     = MUL_W'(x_reg[jidx]);
                    mul_b     = MUL_W'($signed(head.w[jidx]));
                    prod_next = $signed(prod_full[PROD_W-1:0]);
                    if (step_reg == '0) begin
                        acc_next = ACC_W'($signed(head.w[INPUT_COUNT])) <<< FRACTION_BITS;
                        // The product left over here is the previous node's output term.
                        if (node_reg != '0)
                            oacc_next = oacc_reg + ACC_W'(prod_reg);
                    end
                    else begin
                        acc_next = acc_reg + ACC_W'(prod_reg);
                    end
                end
                else if (step_reg == STEP_W'(INPUT_COUNT)) begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                else if (step_reg == STEP_W'(FWD_LAST)) begin
                    mul_a     = MUL_W'($signed({1'b0, sig_y}));
                    mul_b     = MUL_W'($signed(head.wo));
                    prod_next = $signed(prod_full[PROD_W-1:0]);
                    tail_in   = head;
                    tail_in.h = sig_y;
                    shift_en  = 1'b1;
                    step_next = '0;
                    if (node_last)
                        state_next = ST_OUT_SIG;
                    else
                        node_next = node_reg + NW'(1);
                end
            end
            ST_OUT_SIG:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == '0) begin
                    oacc_next = oacc_reg + ACC_W'(prod_reg);
                end
                else if (step_reg == STEP_W'(2)) begin
                    y_next    = sig_y;
                    err_next  = ERR_W'($signed({1'b0, tgt_sat})) -
                                ERR_W'($signed({1'b0, sig_y}));
                    step_next = '0;
                    if (op_reg == OP_INFER)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_OUT_DELTA;
                end
            end
            ST_OUT_DELTA:
            begin
                step_next = step_reg + STEP_W'(1);
                case (step_reg[1:0])
                    2'd0:
                    begin
                        mul_a     = MUL_W'(err_reg);
                        mul_b     = MUL_W'($signed({1'b0, y_reg}));
                        prod_next = $signed(prod_full[PROD_W-1:0]);
                    end
                    2'd1:
                    begin
                        mul_a     = $signed(prod_reg[MUL_W-1:0]);
                        mul_b     = MUL_W'(ONE) - MUL_W'($signed({1'b0, y_reg}));
                        prod_next = $signed(prod_full[PROD_W-1:0]);
                    end
                    2'd2:
                    begin
                        od_next   = od_rnd[WEIGHT_W-1:0];
                        mul_a     = MUL_W'(err_reg);
                        mul_b     = MUL_W'(err_reg);
                        prod_next = $signed(prod_full[PROD_W-1:0]);
                    end
                    default:
                    begin
                        sq_next    = sq_rnd[ACT_W-1:0];
                        step_next  = '0;
                        node_next  = '0;
                        state_next = ST_HID_UPD;
                    end
                endcase
            end
            ST_HID_UPD:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg < STEP_W'(4)) begin
                    case (step_reg[1:0])
                        2'd0:
                        begin
                            work_next = head;
                            mul_a     = MUL_W'($signed(head.wo));
                            mul_b     = MUL_W'(od_reg);
                            prod_next = $signed(prod_full[PROD_W-1:0]);
                        end
                        2'd1:
                        begin
                            tmp_next  = prod_reg[MUL_W-1:0];
                            mul_a     = MUL_W'($signed({1'b0, work_reg.h}));
                            mul_b     = MUL_W'(ONE) - MUL_W'($signed({1'b0, work_reg.h}));
                            prod_next = $signed(prod_full[PROD_W-1:0]);
                        end
                        2'd2:
                        begin
                            mul_a     = tmp_reg;
                            mul_b     = $signed(prod_reg[MUL_W-1:0]);
                            prod_next = $signed(prod_full[PROD_W-1:0]);
                        end
                        default:
                        begin
                            hd_next = hd_rnd[WEIGHT_W-1:0];
                        end
                    endcase
                end
                else begin
                    case (uph)
                        2'd0:
                        begin
                            mul_a     = MUL_W'($signed({1'b0, lr_reg}));
                            mul_b     = upd_x;
                            prod_next = $signed(prod_full[PROD_W-1:0]);
                        end
                        2'd1:
                        begin
                            mul_a     = $signed(prod_reg[MUL_W-1:0]);
                            mul_b     = upd_d;
                            prod_next = $signed(prod_full[PROD_W-1:0]);
                        end
                        2'd2:
                        begin
                            tot_next  = prod_reg;
                            mul_a     = MUL_W'($signed({1'b0, mom_reg}));
                            mul_b     = upd_c;
                            prod_next = $signed(prod_full[PROD_W-1:0]);
                        end
                        default:
                        begin
                            if (kk <= KW'(INPUT_COUNT)) begin
                                work_next.w[kidx] = new_w;
                                work_next.c[kidx] = new_c;
                            end
                            else begin
                                work_next.wo = new_w;
                                work_next.co = new_c;
                            end
                            if (step_reg == STEP_W'(UPD_LAST)) begin
                                tail_in   = work_next;
                                shift_en  = 1'b1;
                                step_next = '0;
                                if (node_last)
                                    state_next = ST_BIAS_UPD;
                                else
                                    node_next = node_reg + NW'(1);
                            end
                        end
                    endcase
                end
            end
            ST_BIAS_UPD:
            begin
                step_next = step_reg + STEP_W'(1);
                case (uph)
                    2'd0:
                    begin
                        mul_a     = MUL_W'($signed({1'b0, lr_reg}));
                        mul_b     = upd_x;
                        prod_next = $signed(prod_full[PROD_W-1:0]);
                    end
                    2'd1:
                    begin
                        mul_a     = $signed(prod_reg[MUL_W-1:0]);
                        mul_b     = upd_d;
                        prod_next = $signed(prod_full[PROD_W-1:0]);
                    end
                    2'd2:
                    begin
                        tot_next  = prod_reg;
                        mul_a     = MUL_W'($signed({1'b0, mom_reg}));
                        mul_b     = upd_c;
                        prod_next = $signed(prod_full[PROD_W-1:0]);
                    end
                    default:
                    begin
                        wob_next   = new_w;
                        cob_next   = new_c;
                        step_next  = '0;
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_ACCESS:
            begin
                // One node passes the head per cycle; the addressed entry is
                // patched or copied out as it goes by.
                acc_rec = head;
                if (idx_ext >= base && idx_ext < base + AW'(INPUT_COUNT + 1)) begin
                    if (op_reg == OP_WRITE) begin
                        acc_rec.w[fsel] = val_reg;
                        acc_rec.c[fsel] = '0;
                    end
                    else begin
                        rd_next = head.w[fsel];
                    end
                end
                if (idx_ext == AW'(HID_W) + AW'(node_reg)) begin
                    if (op_reg == OP_WRITE) begin
                        acc_rec.wo = val_reg;
                        acc_rec.co = '0;
                    end
                    else begin
                        rd_next = head.wo;
                    end
                end
                if (node_reg == '0 && idx_ext == AW'(HID_W + HIDDEN_COUNT)) begin
                    if (op_reg == OP_WRITE) begin
                        wob_next = val_reg;
                        cob_next = '0;
                    end
                    else begin
                        rd_next = wob_reg;
                    end
                end
                tail_in  = acc_rec;
                shift_en = 1'b1;
                if (node_last)
                    state_next = ST_FINISH;
                else
                    node_next = node_reg + NW'(1);
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready) begin
                    out_valid_next = 1'b1;
                    out_act_next   = (op_reg == OP_TRAIN || op_reg == OP_INFER) ? y_reg : '0;
                    out_err_next   = (op_reg == OP_TRAIN) ? err_reg : '0;
                    out_sq_next    = (op_reg == OP_TRAIN) ? sq_reg : '0;
                    out_wr_next    = (op_reg == OP_READ) ? rd_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        lr_next  = lr_reg;
        mom_next = mom_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LEARNING_RATE: lr_next  = cfg_data;
                CFG_MOMENTUM:      mom_next = cfg_data;
                default:           lr_next  = lr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            node_reg      <= '0;
            wob_reg       <= '0;
            cob_reg       <= '0;
            lr_reg        <= LR_RESET;
            mom_reg       <= MOM_RESET;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            node_reg      <= node_next;
            wob_reg       <= wob_next;
            cob_reg       <= cob_next;
            lr_reg        <= lr_next;
            mom_reg       <= mom_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        x_reg       <= x_next;
        tgt_reg     <= tgt_next;
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        acc_reg     <= acc_next;
        oacc_reg    <= oacc_next;
        prod_reg    <= prod_next;
        tmp_reg     <= tmp_next;
        tot_reg     <= tot_next;
        hd_reg      <= hd_next;
        od_reg      <= od_next;
        y_reg       <= y_next;
        err_reg     <= err_next;
        sq_reg      <= sq_next;
        rd_reg      <= rd_next;
        work_reg    <= work_next;
        out_act_reg <= out_act_next;
        out_err_reg <= out_err_next;
        out_sq_reg  <= out_sq_next;
        out_wr_reg  <= out_wr_next;
    end

    assign cmd.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.activation    = out_act_reg;
    assign rsp.output_error  = out_err_reg;
    assign rsp.squared_error = out_sq_reg;
    assign rsp.weight_read   = out_wr_reg;
endmodule

### hw/rtl/mbt_checker.sv
// Port-level checks of the trainer and their binding to the top level.
`timescale 1ns / 1ps
`include "mlp_backprop_momentum_trainer_defines.svh"
module mbt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [10:0] rsp_activation,
    input logic [11:0] rsp_output_error,
    input logic [10:0] rsp_squared_error,
    input logic [15:0] rsp_weight_read
);
    // A stalled result stays offered.
    `MBT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
    // A stalled result keeps its payload.
    `MBT_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_activation) && $stable(rsp_output_error) && $stable(rsp_squared_error) && $stable(rsp_weight_read), "result changed while stalled")
    // Items are worked one at a time, so an accepted item closes the input.
    `MBT_ASSERT_NEXT(a_one_item, cmd_valid && cmd_ready, !cmd_ready, "second item taken while busy")
    // A result carrying a read weight carries no network output.
    `MBT_ASSERT_NOW(a_read_clean, rsp_valid && rsp_weight_read != 16'd0, rsp_activation == 11'd0 && rsp_output_error == 12'd0 && rsp_squared_error == 11'd0, "read result mixed with network output")
endmodule

bind mlp_backprop_momentum_trainer mbt_checker u_mbt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_activation    (rsp.activation),
    .rsp_output_error  (rsp.output_error),
    .rsp_squared_error (rsp.squared_error),
    .rsp_weight_read   (rsp.weight_read)
);
